// ===== rtl/core/sddm_pkg.sv =====
package sddm_pkg;

  // Command and fixed-point widths
  localparam int CMD_W  = 16;
  localparam int FRAC_W = 16;
  localparam int SM_W   = CMD_W + FRAC_W;
  localparam int DIFF_W = SM_W + 2;
  localparam int DIG_W  = 8;
  localparam int ACC_W  = 2 * SM_W;
  localparam int MCNT_W = $clog2(SM_W / DIG_W);
  localparam int DEN_W  = CMD_W - 1;
  localparam int DIV_W  = 2 * SM_W - 2 - FRAC_W;

  // Configuration widths
  localparam int GAIN_W  = 16;
  localparam int DB_W    = 15;
  localparam int PWM_W   = 8;
  localparam int PADDR_W = 5;
  localparam int REG_W   = PADDR_W - 2;
  localparam int PDATA_W = 32;

  // Full scale, in command units and in Q16.16
  localparam logic [DEN_W-1:0]        FS_CMD  = '1;
  localparam logic signed [CMD_W-1:0] CMD_MAX = {1'b0, FS_CMD};
  localparam logic signed [CMD_W-1:0] CMD_NEG = {1'b1, {DEN_W{1'b0}}};
  localparam logic signed [SM_W-1:0]  FSQ     = {1'b0, FS_CMD, {FRAC_W{1'b0}}};

  // Register indexes
  localparam logic [REG_W-1:0] REG_SPEED_GAIN  = 3'd0;
  localparam logic [REG_W-1:0] REG_TURN_GAIN   = 3'd1;
  localparam logic [REG_W-1:0] REG_WEAPON_GAIN = 3'd2;
  localparam logic [REG_W-1:0] REG_DEADBAND    = 3'd3;
  localparam logic [REG_W-1:0] REG_PWM_FULL    = 3'd4;

  // Register reset values
  localparam logic [GAIN_W-1:0] GAIN_RST     = 16'd3277;
  localparam logic [DB_W-1:0]   DEADBAND_RST = 15'd3277;
  localparam logic [PWM_W-1:0]  PWM_FULL_RST = 8'd255;

  typedef struct packed {
    logic signed [CMD_W-1:0] speed_cmd;
    logic signed [CMD_W-1:0] turn_cmd;
    logic signed [CMD_W-1:0] weapon_cmd;
  } cmd_word_t;

  typedef struct packed {
    logic             left_pin_a;
    logic             left_pin_b;
    logic [PWM_W-1:0] left_duty;
    logic             right_pin_a;
    logic             right_pin_b;
    logic [PWM_W-1:0] right_duty;
    logic             kick_pin_a;
    logic [PWM_W-1:0] kick_duty;
  } drive_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SM_LOAD,
    ST_SM_MUL,
    ST_SM_UPD,
    ST_MX_LOAD,
    ST_MX_MUL,
    ST_MX_DIV,
    ST_DT_LOAD,
    ST_DT_MUL,
    ST_DT_DIV,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    CH_SPEED,
    CH_TURN,
    CH_WEAPON
  } chan_t;

  typedef enum logic [1:0] {
    SIDE_LEFT,
    SIDE_RIGHT,
    SIDE_KICK
  } side_t;

endpackage

// ===== rtl/core/smoothed_differential_drive_mixer_core.sv =====
// Smoothed differential-drive mixer: each accepted command word (speed, turn,
// weapon) updates three exponential filters held in Q16.16, mixes left and
// right drive from the filtered speed and turn, and returns one drive word
// with H-bridge pin levels and PWM duties for left, right and weapon motors.
// One word is worked on at a time, using a shared 8-bit-digit serial
// multiplier (two digits per gain, four per mixing factor) and a
// divide-by-32767 loop that folds the dividend in 15-bit digits, up to five
// passes per quotient. A finished word waits in the output register while
// the next command word is taken. The user must write registers over the
// APB port only while no word is in flight; the block does not enforce it.
// Gains are Q0.16 fractions, the deadband is in command units.
module smoothed_differential_drive_mixer_core import sddm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  cmd_word_t           cmd_data,
  output logic                drive_valid,
  input  logic                drive_stall,
  output drive_word_t         drive_data
);

  // Configuration registers
  logic [GAIN_W-1:0] speed_gain;
  logic [GAIN_W-1:0] turn_gain;
  logic [GAIN_W-1:0] weapon_gain;
  logic [DB_W-1:0]   deadband;
  logic [PWM_W-1:0]  pwm_full;

  // Sequencer
  state_t state;
  state_t state_next;
  chan_t  ch;
  side_t  side;

  // Held commands and filter state
  logic signed [CMD_W-1:0] speed_cmd;
  logic signed [CMD_W-1:0] turn_cmd;
  logic signed [CMD_W-1:0] weapon_cmd;
  logic signed [SM_W-1:0]  speed_smooth;
  logic signed [SM_W-1:0]  turn_smooth;
  logic signed [SM_W-1:0]  weapon_smooth;

  // Serial multiplier
  logic signed [DIFF_W-1:0]      mul_a;
  logic [SM_W-1:0]               mul_b;
  logic [MCNT_W-1:0]             mul_cnt;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       acc_next;
  logic signed [DIFF_W+DIG_W:0]  pp;
  logic                          mul_last;

  // Divide-by-full-scale loop
  logic [DIV_W-1:0]       div_y;
  logic [SM_W-1:0]        div_q;
  logic [DIV_W-DEN_W-1:0] div_hi;
  logic [DEN_W-1:0]       div_lo;
  logic                   div_done;
  logic [SM_W-1:0]        div_res;

  // Per-side work registers
  logic [SM_W-1:0] xmag;
  logic            stop;
  logic            neg;
  drive_word_t     res;

  // Datapath selection
  logic signed [CMD_W-1:0]  cmd_sel;
  logic signed [SM_W-1:0]   s_sel;
  logic [GAIN_W-1:0]        gain_sel;
  logic signed [SM_W-1:0]   cmd_fix;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] s_upd;
  logic signed [DIFF_W-1:0] dbq;
  logic                     snap;
  logic signed [SM_W-1:0]   s_new;
  logic [SM_W-1:0]          v_mag;
  logic [SM_W-1:0]          m_sel;
  logic [PWM_W-1:0]         duty_val;
  logic                     cfg_we;
  logic [REG_W-1:0]         reg_idx;
  logic                     out_free;
  logic                     accept;

  function automatic logic signed [CMD_W-1:0] sat_cmd(input logic signed [CMD_W-1:0] x);
    sat_cmd = (x == CMD_NEG) ? -CMD_MAX : x;
  endfunction

  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite;
  assign reg_idx  = paddr[PADDR_W-1:2];
  assign accept   = cmd_valid && !cmd_stall;
  assign out_free = !drive_valid || !drive_stall;

  // Register write
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_gain  <= GAIN_RST;
      turn_gain   <= GAIN_RST;
      weapon_gain <= GAIN_RST;
      deadband    <= DEADBAND_RST;
      pwm_full    <= PWM_FULL_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_SPEED_GAIN:  speed_gain  <= pwdata[GAIN_W-1:0];
        REG_TURN_GAIN:   turn_gain   <= pwdata[GAIN_W-1:0];
        REG_WEAPON_GAIN: weapon_gain <= pwdata[GAIN_W-1:0];
        REG_DEADBAND:    deadband    <= pwdata[DB_W-1:0];
        REG_PWM_FULL:    pwm_full    <= pwdata[PWM_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read
  always_comb begin
    unique case (reg_idx)
      REG_SPEED_GAIN:  prdata = PDATA_W'(speed_gain);
      REG_TURN_GAIN:   prdata = PDATA_W'(turn_gain);
      REG_WEAPON_GAIN: prdata = PDATA_W'(weapon_gain);
      REG_DEADBAND:    prdata = PDATA_W'(deadband);
      REG_PWM_FULL:    prdata = PDATA_W'(pwm_full);
      default:         prdata = '0;
    endcase
  end

  // Pick the filter channel being updated
  always_comb begin
    unique case (ch)
      CH_SPEED: begin
        cmd_sel  = speed_cmd;
        s_sel    = speed_smooth;
        gain_sel = speed_gain;
      end
      CH_TURN: begin
        cmd_sel  = turn_cmd;
        s_sel    = turn_smooth;
        gain_sel = turn_gain;
      end
      CH_WEAPON: begin
        cmd_sel  = weapon_cmd;
        s_sel    = weapon_smooth;
        gain_sel = weapon_gain;
      end
      default: begin
        cmd_sel  = speed_cmd;
        s_sel    = speed_smooth;
        gain_sel = speed_gain;
      end
    endcase
  end

  // Filter step: s + floor(gain * (cmd - s) / 2^16), then deadband snap
  assign cmd_fix = {cmd_sel, {FRAC_W{1'b0}}};
  assign diff    = DIFF_W'(cmd_fix) - DIFF_W'(s_sel);
  assign s_upd   = DIFF_W'(s_sel) + $signed(acc[FRAC_W +: DIFF_W]);
  assign dbq     = DIFF_W'({deadband, {FRAC_W{1'b0}}});
  assign snap    = (cmd_sel == '0) && (s_upd < dbq) && (s_upd > -dbq);
  assign s_new   = snap ? '0 : s_upd[SM_W-1:0];

  // Mixing factors from the filtered turn rate
  assign v_mag = speed_smooth[SM_W-1] ? SM_W'(-speed_smooth) : SM_W'(speed_smooth);

  always_comb begin
    unique case (side)
      SIDE_LEFT:  m_sel = turn_smooth[SM_W-1] ? SM_W'(FSQ) : SM_W'(FSQ - turn_smooth);
      SIDE_RIGHT: m_sel = turn_smooth[SM_W-1] ? SM_W'(FSQ + turn_smooth) : SM_W'(FSQ);
      default:    m_sel = '0;
    endcase
  end

  // One 8-bit digit of the multiplier operand per cycle, top digit first
  assign pp       = mul_a * $signed({1'b0, mul_b[SM_W-1 -: DIG_W]});
  assign acc_next = (acc <<< DIG_W) + ACC_W'(pp);
  assign mul_last = (mul_cnt == '0);

  // Fold 15-bit digits: y = a*2^15 + b gives q += a, y = a + b
  assign div_hi   = div_y[DIV_W-1:DEN_W];
  assign div_lo   = div_y[DEN_W-1:0];
  assign div_done = (div_hi == '0);
  assign div_res  = div_q + SM_W'(div_lo == FS_CMD);
  assign duty_val = (div_res > SM_W'(pwm_full)) ? pwm_full : div_res[PWM_W-1:0];

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and input stall
  always_comb begin
    state_next = state;
    cmd_stall  = 1'b1;
    unique case (state)
      ST_IDLE: begin
        cmd_stall = 1'b0;
        if (cmd_valid) begin
          state_next = ST_SM_LOAD;
        end
      end
      ST_SM_LOAD: state_next = ST_SM_MUL;
      ST_SM_MUL: begin
        if (mul_last) begin
          state_next = ST_SM_UPD;
        end
      end
      ST_SM_UPD: state_next = (ch == CH_WEAPON) ? ST_MX_LOAD : ST_SM_LOAD;
      ST_MX_LOAD: state_next = (side == SIDE_KICK) ? ST_DT_LOAD : ST_MX_MUL;
      ST_MX_MUL: begin
        if (mul_last) begin
          state_next = ST_MX_DIV;
        end
      end
      ST_MX_DIV: begin
        if (div_done) begin
          state_next = ST_DT_LOAD;
        end
      end
      ST_DT_LOAD: state_next = ST_DT_MUL;
      ST_DT_MUL: begin
        if (mul_last) begin
          state_next = ST_DT_DIV;
        end
      end
      ST_DT_DIV: begin
        if (div_done) begin
          state_next = (side == SIDE_KICK) ? ST_FINISH : ST_MX_LOAD;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output handshake: post a finished word, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_valid <= 1'b0;
    end else if ((state == ST_FINISH) && out_free) begin
      drive_valid <= 1'b1;
    end else if (!drive_stall) begin
      drive_valid <= 1'b0;
    end
  end

  // Sequencer indexes and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      ch            <= CH_SPEED;
      side          <= SIDE_LEFT;
      speed_smooth  <= '0;
      turn_smooth   <= '0;
      weapon_smooth <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          ch <= CH_SPEED;
        end
        ST_SM_UPD: begin
          unique case (ch)
            CH_SPEED:  speed_smooth  <= s_new;
            CH_TURN:   turn_smooth   <= s_new;
            CH_WEAPON: weapon_smooth <= s_new;
            default: ;
          endcase
          unique case (ch)
            CH_SPEED:  ch <= CH_TURN;
            CH_TURN:   ch <= CH_WEAPON;
            default:   side <= SIDE_LEFT;
          endcase
        end
        ST_DT_DIV: begin
          if (div_done) begin
            unique case (side)
              SIDE_LEFT:  side <= SIDE_RIGHT;
              SIDE_RIGHT: side <= SIDE_KICK;
              default:    side <= SIDE_LEFT;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // Multiplier, divider and result datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          speed_cmd  <= sat_cmd(cmd_data.speed_cmd);
          turn_cmd   <= sat_cmd(cmd_data.turn_cmd);
          weapon_cmd <= sat_cmd(cmd_data.weapon_cmd);
        end
      end
      ST_SM_LOAD: begin
        mul_a   <= diff;
        mul_b   <= {gain_sel, {(SM_W-GAIN_W){1'b0}}};
        mul_cnt <= MCNT_W'(GAIN_W / DIG_W - 1);
        acc     <= '0;
      end
      ST_SM_MUL, ST_MX_MUL, ST_DT_MUL: begin
        acc     <= acc_next;
        mul_b   <= mul_b << DIG_W;
        mul_cnt <= mul_cnt - 1'b1;
        if (mul_last) begin
          div_y <= acc_next[FRAC_W +: DIV_W];
          div_q <= '0;
        end
      end
      ST_MX_LOAD: begin
        if (side == SIDE_KICK) begin
          xmag <= weapon_smooth;
          stop <= weapon_smooth[SM_W-1] || (weapon_smooth == '0);
          neg  <= 1'b0;
        end else begin
          mul_a   <= DIFF_W'(v_mag);
          mul_b   <= m_sel;
          mul_cnt <= MCNT_W'(SM_W / DIG_W - 1);
          acc     <= '0;
          stop    <= (speed_smooth == '0) || (m_sel == '0);
          neg     <= speed_smooth[SM_W-1];
        end
      end
      ST_MX_DIV: begin
        if (div_done) begin
          xmag <= div_res;
        end else begin
          div_y <= DIV_W'(div_hi) + DIV_W'(div_lo);
          div_q <= div_q + SM_W'(div_hi);
        end
      end
      ST_DT_LOAD: begin
        mul_a   <= DIFF_W'(xmag);
        mul_b   <= {pwm_full, {(SM_W-PWM_W){1'b0}}};
        mul_cnt <= MCNT_W'(PWM_W / DIG_W - 1);
        acc     <= '0;
      end
      ST_DT_DIV: begin
        if (div_done) begin
          unique case (side)
            SIDE_LEFT: begin
              res.left_pin_a <= !stop && !neg;
              res.left_pin_b <= !stop && neg;
              res.left_duty  <= stop ? '0 : duty_val;
            end
            SIDE_RIGHT: begin
              res.right_pin_a <= !stop && neg;
              res.right_pin_b <= !stop && !neg;
              res.right_duty  <= stop ? '0 : duty_val;
            end
            default: begin
              res.kick_pin_a <= !stop;
              res.kick_duty  <= stop ? '0 : duty_val;
            end
          endcase
        end else begin
          div_y <= DIV_W'(div_hi) + DIV_W'(div_lo);
          div_q <= div_q + SM_W'(div_hi);
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          drive_data <= res;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // A new word always starts at the speed filter
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SM_LOAD) && (ch == CH_SPEED))
    else $error("word accepted but filter sequence did not start");

  // Filter state stays within full scale
  assert property (@(posedge clk) disable iff (rst)
    (speed_smooth <= FSQ) && (speed_smooth >= -FSQ) &&
    (turn_smooth <= FSQ) && (turn_smooth >= -FSQ) &&
    (weapon_smooth <= FSQ) && (weapon_smooth >= -FSQ))
    else $error("filter state beyond full scale");

  // Never drive both inputs of one bridge
  assert property (@(posedge clk) disable iff (rst)
    drive_valid |-> !(drive_data.left_pin_a && drive_data.left_pin_b) &&
                    !(drive_data.right_pin_a && drive_data.right_pin_b))
    else $error("both bridge pins high");

  // A finished word is posted and the sequencer returns to idle
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) && out_free |=> drive_valid && (state == ST_IDLE))
    else $error("finished word not posted");
`endif

endmodule

// ===== dv/smoothed_differential_drive_mixer_core_tb.sv =====
module smoothed_differential_drive_mixer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sddm_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int DRAIN_CYCLES = 100;
  localparam int LONG_HOLD    = 600;

  // Addresses past the last register; writes there must change nothing
  localparam logic [REG_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [REG_W-1:0] REG_SPARE_HI = 3'd7;

  localparam longint FS_C = longint'(FS_CMD);
  localparam longint FS_Q = longint'(FSQ);

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_style_t;

  logic               clk;
  logic               rst         = 1'b1;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [PDATA_W-1:0] pwdata      = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               cmd_valid   = 1'b0;
  logic               cmd_stall;
  cmd_word_t          cmd_data    = '0;
  logic               drive_valid;
  logic               drive_stall = 1'b0;
  drive_word_t        drive_data;

  smoothed_differential_drive_mixer_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd_data    (cmd_data),
    .drive_valid (drive_valid),
    .drive_stall (drive_stall),
    .drive_data  (drive_data)
  );

  // Register shadows, written alongside the block's registers
  logic [GAIN_W-1:0] cfg_speed_gain  = GAIN_RST;
  logic [GAIN_W-1:0] cfg_turn_gain   = GAIN_RST;
  logic [GAIN_W-1:0] cfg_weapon_gain = GAIN_RST;
  logic [DB_W-1:0]   cfg_deadband    = DEADBAND_RST;
  logic [PWM_W-1:0]  cfg_pwm_full    = PWM_FULL_RST;

  // Filter state in Q16.16
  longint speed_q  = 0;
  longint turn_q   = 0;
  longint weapon_q = 0;

  cmd_word_t    cmd_pending[$];
  drive_word_t  drive_expected[$];
  int           mismatch_count = 0;
  int           cycle_count    = 0;
  int           burst_left     = 0;
  int           gap_left       = 0;
  bit           gapless        = 1'b0;
  bit           long_hold_req  = 1'b0;
  int           hold_left      = 0;
  stall_style_t stall_style    = STALL_RANDOM;
  logic [15:0]  stall_pattern  = 16'h3c5a;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void shadow_write(logic [REG_W-1:0] idx, logic [PDATA_W-1:0] val);
    case (idx)
      REG_SPEED_GAIN:  cfg_speed_gain  = val[GAIN_W-1:0];
      REG_TURN_GAIN:   cfg_turn_gain   = val[GAIN_W-1:0];
      REG_WEAPON_GAIN: cfg_weapon_gain = val[GAIN_W-1:0];
      REG_DEADBAND:    cfg_deadband    = val[DB_W-1:0];
      REG_PWM_FULL:    cfg_pwm_full    = val[PWM_W-1:0];
      default: ;
    endcase
  endfunction

  // Most negative pattern saturates to minus full scale
  function automatic longint sat_cmd(logic signed [CMD_W-1:0] raw);
    longint v;
    v = longint'(raw);
    if (v < -FS_C) v = -FS_C;
    return v;
  endfunction

  // One exponential filter update with deadband snap on a zero command
  function automatic longint filter_step(longint s, longint cmd, logic [GAIN_W-1:0] gain);
    longint d;
    longint n;
    longint mag;
    d = cmd * 65536 - s;
    n = s + ((longint'(gain) * d) >>> 16);
    mag = (n < 0) ? -n : n;
    if (cmd == 0 && mag < longint'(cfg_deadband) * 65536) n = 0;
    return n;
  endfunction

  function automatic logic [PWM_W-1:0] duty_of(longint mag);
    longint du;
    du = (longint'(cfg_pwm_full) * mag) / FS_Q;
    if (du > longint'(cfg_pwm_full)) du = longint'(cfg_pwm_full);
    return du[PWM_W-1:0];
  endfunction

  // Scale speed by a side factor; stop the side when either is zero
  function automatic void side_drive(longint v, longint m, output logic fwd,
                                     output logic rev, output logic [PWM_W-1:0] duty);
    longint av;
    fwd  = 1'b0;
    rev  = 1'b0;
    duty = '0;
    if (v != 0 && m > 0) begin
      av   = (v < 0) ? -v : v;
      duty = duty_of((av * m) / FS_Q);
      fwd  = (v > 0);
      rev  = (v < 0);
    end
  endfunction

  // Advance the filters by one tick and mix the drive word
  function automatic drive_word_t mix_tick(cmd_word_t w);
    drive_word_t r;
    longint m_left;
    longint m_right;
    speed_q  = filter_step(speed_q, sat_cmd(w.speed_cmd), cfg_speed_gain);
    turn_q   = filter_step(turn_q, sat_cmd(w.turn_cmd), cfg_turn_gain);
    weapon_q = filter_step(weapon_q, sat_cmd(w.weapon_cmd), cfg_weapon_gain);
    m_left  = (turn_q >= 0) ? FS_Q - turn_q : FS_Q;
    m_right = (turn_q <= 0) ? FS_Q + turn_q : FS_Q;
    side_drive(speed_q, m_left, r.left_pin_a, r.left_pin_b, r.left_duty);
    // right bridge is wired inverted: pin b forward, pin a reverse
    side_drive(speed_q, m_right, r.right_pin_b, r.right_pin_a, r.right_duty);
    r.kick_pin_a = (weapon_q > 0);
    r.kick_duty  = (weapon_q > 0) ? duty_of(weapon_q) : '0;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_bits(string field, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
  endtask

  // Sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && !cmd_stall) drive_expected.push_back(mix_tick(cmd_data));
      if (!cmd_valid || !cmd_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          cmd_valid <= 1'b0;
        end else if (cmd_pending.size() > 0) begin
          cmd_valid <= 1'b1;
          cmd_data  <= cmd_pending.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 11);
            if (gapless || $urandom_range(0, 3) == 0) gap_left = 0;
            else gap_left = $urandom_range(1, 20);
          end
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each accepted word, then pick the next stall
  always @(posedge clk) begin
    drive_word_t want;
    if (!rst) begin
      if (drive_valid && !drive_stall) begin
        if (drive_expected.size() == 0) begin
          report_mismatch("drive word with no command outstanding");
        end else begin
          want = drive_expected.pop_front();
          check_bits("left_pin_a", 8'(drive_data.left_pin_a), 8'(want.left_pin_a));
          check_bits("left_pin_b", 8'(drive_data.left_pin_b), 8'(want.left_pin_b));
          check_bits("left_duty", drive_data.left_duty, want.left_duty);
          check_bits("right_pin_a", 8'(drive_data.right_pin_a), 8'(want.right_pin_a));
          check_bits("right_pin_b", 8'(drive_data.right_pin_b), 8'(want.right_pin_b));
          check_bits("right_duty", drive_data.right_duty, want.right_duty);
          check_bits("kick_pin_a", 8'(drive_data.kick_pin_a), 8'(want.kick_pin_a));
          check_bits("kick_duty", drive_data.kick_duty, want.kick_duty);
        end
      end
      if (long_hold_req) begin
        hold_left     = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        drive_stall <= 1'b1;
      end else begin
        case (stall_style)
          STALL_NONE:    drive_stall <= 1'b0;
          STALL_RANDOM:  drive_stall <= ($urandom_range(0, 2) == 0);
          default:       drive_stall <= stall_pattern[0];
        endcase
      end
      if ($urandom_range(0, 63) == 0) stall_pattern <= 16'($urandom);
      else stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic reg_write(logic [REG_W-1:0] idx, logic [PDATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow_write(idx, val);
  endtask

  task automatic push_cmd(logic signed [CMD_W-1:0] s, logic signed [CMD_W-1:0] t,
                          logic signed [CMD_W-1:0] k);
    cmd_word_t w;
    w.speed_cmd  = s;
    w.turn_cmd   = t;
    w.weapon_cmd = k;
    cmd_pending.push_back(w);
  endtask

  function automatic logic signed [CMD_W-1:0] rand_cmd();
    logic signed [CMD_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = CMD_MAX;
      1: v = -CMD_MAX;
      2: v = CMD_NEG;
      3: begin
        v = CMD_W'($urandom_range(1, 40));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = CMD_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic signed [CMD_W-1:0] run_field();
    return ($urandom_range(0, 3) == 0) ? '0 : rand_cmd();
  endfunction

  // Mostly held commands so the filters settle, with some single-word noise
  task automatic add_runs(int n);
    cmd_word_t w;
    int run_len;
    int added;
    added = 0;
    while (added < n) begin
      if ($urandom_range(0, 5) == 0) begin
        w.speed_cmd  = CMD_W'($urandom);
        w.turn_cmd   = CMD_W'($urandom);
        w.weapon_cmd = CMD_W'($urandom);
        run_len = 1;
      end else begin
        w.speed_cmd  = run_field();
        w.turn_cmd   = run_field();
        w.weapon_cmd = run_field();
        run_len = $urandom_range(1, 24);
      end
      for (int i = 0; i < run_len && added < n; i++) begin
        cmd_pending.push_back(w);
        added++;
      end
    end
  endtask

  // Wait until the sender is empty and every drive word has come back
  task automatic wait_drained();
    @(negedge clk);
    while (cmd_pending.size() != 0 || cmd_valid || drive_expected.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(logic [PDATA_W-1:0] g_speed, logic [PDATA_W-1:0] g_turn,
                           logic [PDATA_W-1:0] g_weapon, logic [PDATA_W-1:0] db,
                           logic [PDATA_W-1:0] pwm, int n_items, stall_style_t style,
                           bit no_gaps, bit hold);
    reg_write(REG_SPEED_GAIN, g_speed);
    reg_write(REG_TURN_GAIN, g_turn);
    reg_write(REG_WEAPON_GAIN, g_weapon);
    reg_write(REG_DEADBAND, db);
    reg_write(REG_PWM_FULL, pwm);
    reg_write(REG_SPARE_LO, $urandom);
    reg_write(REG_SPARE_HI, $urandom);
    @(negedge clk);
    stall_style = style;
    gapless     = no_gaps;
    add_runs(n_items);
    if (hold) long_hold_req = 1'b1;
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: snap, tiny drive, extremes of speed, turn and weapon
    push_cmd(0, 0, 0);
    push_cmd(16'sd4000, -16'sd4000, 16'sd4000);
    push_cmd(0, 0, 0);
    push_cmd(16'sd1, 0, 16'sd1);
    push_cmd(-16'sd1, 0, 0);
    repeat (4) push_cmd(CMD_MAX, 0, CMD_MAX);
    repeat (2) push_cmd(CMD_MAX, CMD_MAX, CMD_NEG);
    repeat (3) push_cmd(CMD_NEG, CMD_NEG, -CMD_MAX);
    repeat (2) push_cmd(CMD_MAX, -CMD_MAX, 0);
    repeat (2) push_cmd(-CMD_MAX, CMD_MAX, 0);
    repeat (2) push_cmd(0, 0, 0);
    wait_drained();

    // Random phases across register settings, extremes first
    run_phase(32'hffff, 32'hffff, 32'hffff, 0, 32'hff, 70, STALL_RANDOM, 1'b0, 1'b0);
    run_phase(0, 0, 0, 32'h7fff, 0, 40, STALL_PATTERN, 1'b0, 1'b0);
    run_phase($urandom, $urandom, $urandom, $urandom, $urandom, 80, STALL_PATTERN,
              1'b1, 1'b1);
    run_phase(1, 1, 1, 1, 1, 40, STALL_NONE, 1'b1, 1'b0);
    run_phase($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 4000), $urandom_range(0, 255), 80, STALL_RANDOM,
              1'b0, 1'b0);
    run_phase(32'h8000, 32'h8000, 32'h8000, PDATA_W'(DEADBAND_RST), 200, 70,
              STALL_PATTERN, 1'b0, 1'b0);
    run_phase(PDATA_W'(GAIN_RST), PDATA_W'(GAIN_RST), PDATA_W'(GAIN_RST),
              PDATA_W'(DEADBAND_RST), PDATA_W'(PWM_FULL_RST), 70, STALL_RANDOM,
              1'b0, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
